/* src/dss_pkg.sv */
// Shared types and codes for the dual stack shared store.
package dss_pkg;

  // Field widths
  localparam int CNT_W   = 9;
  localparam int WORD_W  = 32;
  localparam int FIDX_W  = 8;
  localparam int ADDR_W  = 3;

  // Largest capacity a register write can select
  localparam logic [CNT_W-1:0] CAP_MAX = 9'd256;

  // Operation codes
  localparam logic [2:0] FUNC_PUSH   = 3'd0;
  localparam logic [2:0] FUNC_POP    = 3'd1;
  localparam logic [2:0] FUNC_PEEK   = 3'd2;
  localparam logic [2:0] FUNC_CLEAR  = 3'd3;
  localparam logic [2:0] FUNC_SEARCH = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // Register index of the capacity register
  localparam logic REG_CAPACITY = 1'b0;

  // Configuration handed to the sequencer
  typedef struct packed {
    logic [CNT_W-1:0] capacity;
    logic             clear;
  } cfg_t;

endpackage

/* src/dss_ifs.sv */
// Valid/ready channel interfaces for request and response words.
interface dss_req_if import dss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        func;
  logic              which_stack;
  logic signed [WORD_W-1:0] value;

  modport source(output valid, func, which_stack, value, input ready);
  modport sink(input valid, func, which_stack, value, output ready);
endinterface

interface dss_rsp_if import dss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic signed [WORD_W-1:0] data;
  logic [FIDX_W-1:0] found_index;
  logic [CNT_W-1:0]  stack_count;
  logic              stack_empty;
  logic              store_full;

  modport source(output valid, status, data, found_index, stack_count, stack_empty,
                 store_full, input ready);
  modport sink(input valid, status, data, found_index, stack_count, stack_empty,
               store_full, output ready);
endinterface

/* src/dss_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/dss_cfg.sv */
// APB-style capacity register with range limiting.
module dss_cfg import dss_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  // Capacity never exceeds the store depth
  localparam logic [CNT_W-1:0] CAP_LIM = (DEPTH < 256) ? CNT_W'(DEPTH) : CAP_MAX;

  logic [CNT_W-1:0] capacity;
  logic [CNT_W-1:0] capacity_next;
  logic             wr_cap;

  assign pready = 1'b1;
  assign wr_cap = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_CAPACITY);

  // Saturate the written value
  always_comb begin
    capacity_next = pwdata[CNT_W-1:0];
    if (capacity_next > CAP_LIM) begin
      capacity_next = CAP_LIM;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_LIM;
    end else if (wr_cap) begin
      capacity <= capacity_next;
    end
  end

  // Read back
  assign prdata = (paddr[ADDR_W-1:2] == REG_CAPACITY) ? {{(32-CNT_W){1'b0}}, capacity} : '0;

  // A capacity write empties both stacks in the same cycle
  assign cfg.capacity = capacity;
  assign cfg.clear    = wr_cap;

endmodule

/* src/dss_seq.sv */
// Operation sequencer: stack counts, store accesses, search scan and result register.
module dss_seq import dss_pkg::*; #(
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  dss_req_if.sink           req,
  dss_rsp_if.source         rsp,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output logic [WORD_W-1:0] mem_wdata,
  output logic [AW-1:0]     mem_raddr,
  input  logic [WORD_W-1:0] mem_rdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]        state;

  // Item held for the whole operation
  logic [2:0]        func;
  logic              sel_b;
  logic [WORD_W-1:0] key;

  logic [CNT_W-1:0]  count_a;
  logic [CNT_W-1:0]  count_b;
  logic [CNT_W-1:0]  k;

  // Result held until the output register is free
  logic [1:0]        res_status;
  logic [WORD_W-1:0] res_data;
  logic [FIDX_W-1:0] res_fidx;

  logic [CNT_W-1:0]  cnt;
  logic              full;
  logic [CNT_W-1:0]  k_next;
  logic [CNT_W-1:0]  idx_first;
  logic [CNT_W-1:0]  idx_cur;
  logic [CNT_W-1:0]  idx_next;
  logic [CNT_W-1:0]  idx_push;
  logic              out_free;
  logic [1:0]        exec_status;
  logic [2:0]        exec_state;

  assign cnt      = sel_b ? count_b : count_a;
  assign full     = ({1'b0, count_a} + {1'b0, count_b}) >= {1'b0, cfg.capacity};
  assign k_next   = k + 9'd1;
  assign out_free = !rsp.valid || rsp.ready;

  // Store index of the k-th word from the top: B sits at capacity-count and up,
  // A at count-1 and down
  assign idx_first = sel_b ? cfg.capacity - cnt : cnt - 9'd1;
  assign idx_cur   = sel_b ? cfg.capacity - cnt + k : cnt - 9'd1 - k;
  assign idx_next  = sel_b ? cfg.capacity - cnt + k_next : cnt - 9'd1 - k_next;
  assign idx_push  = sel_b ? cfg.capacity - 9'd1 - count_b : count_a;

  assign req.ready = (state == S_IDLE);

  // Store ports; items run one at a time so a write never overlaps a read of it
  assign mem_we    = (state == S_EXEC) && (func == FUNC_PUSH) && !full;
  assign mem_waddr = AW'(idx_push);
  assign mem_wdata = key;
  assign mem_raddr = (state == S_SCAN) ? AW'(idx_next) : AW'(idx_first);

  // Status and follow-on state decided in the execute cycle
  always_comb begin
    exec_status = ST_OK;
    exec_state  = S_DONE;
    unique case (func)
      FUNC_PUSH: begin
        if (full) begin
          exec_status = ST_FULL;
        end
      end
      FUNC_POP, FUNC_PEEK: begin
        if (cnt == '0) begin
          exec_status = ST_EMPTY;
        end else begin
          exec_state = S_READ;
        end
      end
      FUNC_SEARCH: begin
        if (cnt == '0) begin
          exec_status = ST_NOT_FOUND;
        end else begin
          exec_state = S_SCAN;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count_a   <= '0;
      count_b   <= '0;
      rsp.valid <= 1'b0;
    end else begin
      // Output word valid until taken
      if (state == S_DONE && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            func  <= req.func;
            sel_b <= req.which_stack;
            key   <= req.value;
            state <= S_EXEC;
          end
        end

        S_EXEC: begin
          res_status <= exec_status;
          res_data   <= '0;
          res_fidx   <= '0;
          k          <= '0;
          state      <= exec_state;
          unique case (func)
            FUNC_PUSH: begin
              if (!full) begin
                if (sel_b) begin
                  count_b <= count_b + 9'd1;
                end else begin
                  count_a <= count_a + 9'd1;
                end
              end
            end
            FUNC_CLEAR: begin
              if (sel_b) begin
                count_b <= '0;
              end else begin
                count_a <= '0;
              end
            end
            default: begin
            end
          endcase
        end

        // Top word arrives from the store
        S_READ: begin
          res_data <= mem_rdata;
          if (func == FUNC_POP) begin
            if (sel_b) begin
              count_b <= count_b - 9'd1;
            end else begin
              count_a <= count_a - 9'd1;
            end
          end
          state <= S_DONE;
        end

        // One word compared per cycle, next read already issued
        S_SCAN: begin
          if (mem_rdata == key) begin
            res_fidx <= idx_cur[FIDX_W-1:0];
            state    <= S_DONE;
          end else if (k_next == cnt) begin
            res_status <= ST_NOT_FOUND;
            state      <= S_DONE;
          end else begin
            k <= k_next;
          end
        end

        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase

      // Capacity write empties both stacks
      if (cfg.clear) begin
        count_a <= '0;
        count_b <= '0;
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      rsp.status      <= res_status;
      rsp.data        <= res_data;
      rsp.found_index <= res_fidx;
      rsp.stack_count <= cnt;
      rsp.stack_empty <= (cnt == '0);
      rsp.store_full  <= full;
    end
  end

endmodule

/* src/dual_stack_shared_store.sv */
// Dual stack shared store: two word stacks sharing one memory, APB capacity register.
//
// Stack A grows up from entry 0 and stack B grows down from entry capacity-1 of
// one synchronous RAM. Items are handled one at a time by a sequencer around
// the single-read-port memory: push, clear and unknown operations go through an
// execute and a done state, pop and peek add one memory read, and search scans
// from the top word down and stops at the first match or at the bottom word.
// The scan reads one word per cycle. A finished result sits in an output
// register, and the block takes the next word while it waits.
// The memory is not cleared at reset; only entries that were pushed are read.
// Writing the capacity register empties both stacks.
module dual_stack_shared_store import dss_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  dss_req_if.sink           req,
  dss_rsp_if.source         rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int AW = $clog2(DEPTH);

  cfg_t              cfg;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  dss_cfg #(.DEPTH(DEPTH)) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dss_seq #(.DEPTH(DEPTH)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req       (req),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  dss_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Testbench for the dual stack shared store: directed table, then random phases.
module testbench import dss_pkg::*; ();

  localparam int MEM_DEPTH = 256;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [ADDR_W-1:0] CAP_ADDR = ADDR_W'({REG_CAPACITY, 2'b00});
  localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
  localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;
  localparam logic STACK_A = 1'b0;
  localparam logic STACK_B = 1'b1;

  // One request word and one response word
  typedef struct packed {
    logic [2:0]        func;
    logic              which_stack;
    logic [WORD_W-1:0] value;
  } stack_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [WORD_W-1:0] data;
    logic [FIDX_W-1:0] found_index;
    logic [CNT_W-1:0]  stack_count;
    logic              stack_empty;
    logic              store_full;
  } stack_result_t;

  typedef enum logic { ROW_WORD, ROW_CAPACITY } row_kind_t;

  typedef struct {
    row_kind_t     kind;
    stack_word_t   w;
    logic [31:0]   cap_data;
    bit            typed;
    stack_result_t want;
  } plan_row_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  dss_req_if req_ch ();
  dss_rsp_if rsp_ch ();

  dual_stack_shared_store dut (
    .clk, .rst, .req(req_ch), .rsp(rsp_ch),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Mirror of the two stacks and the shared store
  logic [WORD_W-1:0] mirror_mem [0:MEM_DEPTH-1];
  int unsigned mir_cnt_a, mir_cnt_b, mir_cap;

  stack_result_t pending_results[$];
  plan_row_t plan_q[$];

  int snd_idle_pct = 28;
  int rsp_idle_pct = 68;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  int cap_writes = 0;
  int full_refusals = 0;
  int search_hits = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Capacity register: low 9 bits, saturated at the largest size
  function automatic int unsigned clip_capacity(logic [31:0] raw);
    int unsigned c;
    c = raw[CNT_W-1:0];
    if (c > CAP_MAX) c = CAP_MAX;
    if (c > MEM_DEPTH) c = MEM_DEPTH;
    return c;
  endfunction

  // Predict one response and advance the mirror
  function automatic stack_result_t stacks_apply(stack_word_t w);
    stack_result_t r;
    int unsigned n, idx, k;
    bit full, hit;
    r = '0;
    hit = 1'b0;
    n = w.which_stack ? mir_cnt_b : mir_cnt_a;
    full = (mir_cnt_a + mir_cnt_b) >= mir_cap;
    case (w.func)
      FUNC_PUSH: begin
        if (full) begin
          r.status = ST_FULL;
        end else begin
          idx = w.which_stack ? mir_cap - 1 - n : n;
          mirror_mem[idx] = w.value;
          n++;
        end
      end
      FUNC_POP, FUNC_PEEK: begin
        if (n == 0) begin
          r.status = ST_EMPTY;
        end else begin
          idx = w.which_stack ? mir_cap - n : n - 1;
          r.data = mirror_mem[idx];
          if (w.func == FUNC_POP) n--;
        end
      end
      FUNC_CLEAR: n = 0;
      FUNC_SEARCH: begin
        // scan from the top toward the bottom, first match wins
        r.status = ST_NOT_FOUND;
        for (k = 0; k < n && !hit; k++) begin
          idx = w.which_stack ? mir_cap - n + k : n - 1 - k;
          if (mirror_mem[idx] == w.value) begin
            hit = 1'b1;
            r.status = ST_OK;
            r.found_index = idx[FIDX_W-1:0];
          end
        end
      end
      default: ;
    endcase
    if (w.which_stack) mir_cnt_b = n;
    else mir_cnt_a = n;
    r.stack_count = n[CNT_W-1:0];
    r.stack_empty = (n == 0);
    r.store_full = (mir_cnt_a + mir_cnt_b) >= mir_cap;
    return r;
  endfunction

  function automatic stack_result_t result_of(logic [1:0] st, logic [WORD_W-1:0] d,
                                              logic [FIDX_W-1:0] fi, logic [CNT_W-1:0] cnt,
                                              logic em, logic fu);
    stack_result_t r;
    r.status = st;
    r.data = d;
    r.found_index = fi;
    r.stack_count = cnt;
    r.stack_empty = em;
    r.store_full = fu;
    return r;
  endfunction

  // Directed table builders
  function automatic void plan_word(logic [2:0] f, logic s, logic [WORD_W-1:0] v);
    plan_row_t row;
    row.kind = ROW_WORD;
    row.w = '{func: f, which_stack: s, value: v};
    row.cap_data = '0;
    row.typed = 1'b0;
    row.want = '0;
    plan_q.push_back(row);
  endfunction

  function automatic void plan_checked(logic [2:0] f, logic s, logic [WORD_W-1:0] v,
                                       stack_result_t want);
    plan_row_t row;
    row.kind = ROW_WORD;
    row.w = '{func: f, which_stack: s, value: v};
    row.cap_data = '0;
    row.typed = 1'b1;
    row.want = want;
    plan_q.push_back(row);
  endfunction

  function automatic void plan_capacity(logic [31:0] v);
    plan_row_t row;
    row.kind = ROW_CAPACITY;
    row.w = '0;
    row.cap_data = v;
    row.typed = 1'b0;
    row.want = '0;
    plan_q.push_back(row);
  endfunction

  // Word at a given depth from the bottom of one stack
  function automatic logic [WORD_W-1:0] stacked_word(logic s, int unsigned k);
    return mirror_mem[s ? mir_cap - 1 - k : k];
  endfunction

  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4, 5: return WORD_W'($urandom_range(7));
      default: return WORD_W'($urandom);
    endcase
  endfunction

  // Random word: pushes by weight, the rest mostly pops, peeks and searches
  function automatic stack_word_t pick_word(int push_pct, int clear_pct);
    stack_word_t w;
    int unsigned n;
    int roll;
    w.which_stack = 1'($urandom_range(1));
    w.value = random_word();
    n = w.which_stack ? mir_cnt_b : mir_cnt_a;
    if ($urandom_range(99) < push_pct) begin
      w.func = FUNC_PUSH;
    end else begin
      roll = $urandom_range(99);
      if (roll < clear_pct) w.func = FUNC_CLEAR;
      else if (roll < clear_pct + 4) w.func = 3'($urandom_range(FUNC_UNUSED_HI, FUNC_UNUSED_LO));
      else if (roll < 40) w.func = FUNC_POP;
      else if (roll < 55) w.func = FUNC_PEEK;
      else w.func = FUNC_SEARCH;
      // most searches look for a word that is really there
      if (w.func == FUNC_SEARCH && n > 0 && $urandom_range(99) < 60)
        w.value = stacked_word(w.which_stack, $urandom_range(n - 1));
    end
    return w;
  endfunction

  // Offer one word, wait for the handshake, then log its prediction
  task automatic offer_word(stack_word_t w, bit typed, stack_result_t want);
    stack_result_t r;
    while ($urandom_range(99) < snd_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.func <= w.func;
    req_ch.which_stack <= w.which_stack;
    req_ch.value <= w.value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    r = stacks_apply(w);
    words_sent++;
    if (r.status == ST_FULL) full_refusals++;
    if (w.func == FUNC_SEARCH && r.status == ST_OK) search_hits++;
    pending_results.push_back(typed ? want : r);
  endtask

  // Stop offering and wait until every response is back
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of the capacity register; both stacks restart empty
  task automatic write_capacity(logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CAP_ADDR;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    mir_cap = clip_capacity(v);
    mir_cnt_a = 0;
    mir_cnt_b = 0;
    cap_writes++;
  endtask

  task automatic run_phase(logic [31:0] cap_data, int snd, int rsp, int n,
                           int push_pct, int clear_pct, bit long_hold);
    drain();
    snd_idle_pct = snd;
    rsp_idle_pct = rsp;
    write_capacity(cap_data);
    // long receiver stall while words keep coming
    if (long_hold) hold_token <= hold_token + 1;
    repeat (n) offer_word(pick_word(push_pct, clear_pct), 1'b0, '0);
  endtask

  task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Compare one accepted response with the oldest prediction
  task automatic check_response();
    stack_result_t want, got;
    got.status = rsp_ch.status;
    got.data = rsp_ch.data;
    got.found_index = rsp_ch.found_index;
    got.stack_count = rsp_ch.stack_count;
    got.stack_empty = rsp_ch.stack_empty;
    got.store_full = rsp_ch.store_full;
    results_seen++;
    if (pending_results.size() == 0) begin
      errors++;
      $display("%0t: response with none expected, actual %0h", $time, got);
    end else begin
      want = pending_results.pop_front();
      report_field("status", want.status, got.status);
      report_field("data", want.data, got.data);
      report_field("found_index", want.found_index, got.found_index);
      report_field("stack_count", want.stack_count, got.stack_count);
      report_field("stack_empty", want.stack_empty, got.stack_empty);
      report_field("store_full", want.store_full, got.store_full);
    end
  endtask

  // Response side: check, then choose ready for the next edge
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) check_response();
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = LONG_HOLD;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
    end
  end

  // Stimulus
  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.func = FUNC_PUSH;
    req_ch.which_stack = STACK_A;
    req_ch.value = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mir_cnt_a = 0;
    mir_cnt_b = 0;
    mir_cap = clip_capacity(32'd256);

    // after reset: empty stacks, full capacity
    plan_checked(FUNC_POP, STACK_A, 32'h0, result_of(ST_EMPTY, 0, 0, 0, 1, 0));
    plan_checked(FUNC_PEEK, STACK_B, 32'h0, result_of(ST_EMPTY, 0, 0, 0, 1, 0));
    plan_checked(FUNC_SEARCH, STACK_A, 32'h0, result_of(ST_NOT_FOUND, 0, 0, 0, 1, 0));
    // extreme words on both stacks
    plan_checked(FUNC_PUSH, STACK_A, 32'h7FFF_FFFF, result_of(ST_OK, 0, 0, 1, 0, 0));
    plan_checked(FUNC_PUSH, STACK_A, 32'h8000_0000, result_of(ST_OK, 0, 0, 2, 0, 0));
    plan_checked(FUNC_PUSH, STACK_B, 32'hFFFF_FFFF, result_of(ST_OK, 0, 0, 1, 0, 0));
    plan_checked(FUNC_PUSH, STACK_B, 32'h0000_0000, result_of(ST_OK, 0, 0, 2, 0, 0));
    plan_checked(FUNC_PEEK, STACK_A, 32'h0, result_of(ST_OK, 32'h8000_0000, 0, 2, 0, 0));
    plan_checked(FUNC_SEARCH, STACK_A, 32'h7FFF_FFFF, result_of(ST_OK, 0, 0, 2, 0, 0));
    plan_checked(FUNC_SEARCH, STACK_B, 32'hFFFF_FFFF, result_of(ST_OK, 0, 255, 2, 0, 0));
    plan_checked(FUNC_SEARCH, STACK_B, 32'h1234_5678,
                 result_of(ST_NOT_FOUND, 0, 0, 2, 0, 0));
    plan_checked(FUNC_POP, STACK_B, 32'h0, result_of(ST_OK, 32'h0, 0, 1, 0, 0));
    // unknown operations change nothing
    plan_checked(FUNC_UNUSED_HI, STACK_A, 32'hDEAD_BEEF, result_of(ST_OK, 0, 0, 2, 0, 0));
    plan_word(FUNC_UNUSED_LO, STACK_B, 32'h5555_AAAA);
    // clear touches the selected stack only; search on an empty stack
    plan_checked(FUNC_CLEAR, STACK_A, 32'h0, result_of(ST_OK, 0, 0, 0, 1, 0));
    plan_checked(FUNC_SEARCH, STACK_A, 32'h7FFF_FFFF,
                 result_of(ST_NOT_FOUND, 0, 0, 0, 1, 0));
    // zero capacity: always full
    plan_capacity(32'hFFFF_FE00);
    plan_checked(FUNC_PUSH, STACK_A, 32'h1, result_of(ST_FULL, 0, 0, 0, 1, 1));
    plan_checked(FUNC_POP, STACK_B, 32'h0, result_of(ST_EMPTY, 0, 0, 0, 1, 1));
    // one entry: B's bottom sits at entry zero
    plan_capacity(32'd1);
    plan_checked(FUNC_PUSH, STACK_B, 32'h5A5A_5A5A, result_of(ST_OK, 0, 0, 1, 0, 1));
    plan_checked(FUNC_PUSH, STACK_A, 32'h3, result_of(ST_FULL, 0, 0, 0, 1, 1));
    plan_checked(FUNC_SEARCH, STACK_B, 32'h5A5A_5A5A, result_of(ST_OK, 0, 0, 1, 0, 1));
    // capacity above range saturates
    plan_capacity(32'h0000_01FF);
    plan_checked(FUNC_PUSH, STACK_B, 32'h6, result_of(ST_OK, 0, 0, 1, 0, 0));
    plan_checked(FUNC_SEARCH, STACK_B, 32'h6, result_of(ST_OK, 0, 255, 1, 0, 0));
    plan_word(FUNC_UNUSED_LO + 3'd1, STACK_A, 32'h0F0F_0F0F);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (plan_q[i]) begin
      if (plan_q[i].kind == ROW_CAPACITY) begin
        drain();
        write_capacity(plan_q[i].cap_data);
      end else begin
        offer_word(plan_q[i].w, plan_q[i].typed, plan_q[i].want);
      end
    end

    // random phases: receiver idles, then sender idles, then neither
    run_phase(32'hA5A5_0011, 28, 68, 170, 45, 6, 1'b0);
    run_phase(32'd2, 68, 28, 60, 45, 6, 1'b0);
    run_phase(32'd5, 68, 28, 110, 50, 6, 1'b0);
    run_phase(32'd300, 0, 0, 320, 90, 0, 1'b1);
    run_phase(32'd1, 0, 0, 40, 50, 6, 1'b0);

    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d words, %0d responses, %0d capacity writes", words_sent,
             results_seen, cap_writes);
    $display("refused pushes on a full store: %0d, searches that hit: %0d",
             full_refusals, search_hits);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(64'd20_000_000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
